// File: rtl/core/mfps_pkg.sv
// ----------------------------------------------------------------------------
// mfps_pkg
// Shared widths, types and defaults of the minimum falling path sum block.
// ----------------------------------------------------------------------------
package mfps_pkg;

  localparam int ELEM_W       = 16;
  localparam int SUM_W        = 24;
  localparam int CFG_W        = 7;
  localparam int MAX_SIZE_DEF = 64;
  localparam int SIZE_RST     = 64;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // Position of the element now at the input, relative to the matrix.
  typedef struct packed {
    logic first_row;
    logic last_row;
    logic first_col;
    logic last_col;
    logic has_right;
  } pos_t;

endpackage

// File: rtl/core/mfps_cell.sv
// ----------------------------------------------------------------------------
// mfps_cell
// One slot of the best-sum shift line: loads the fresh sum or its neighbor.
// ----------------------------------------------------------------------------
module mfps_cell (
  input  logic          clk,
  input  logic          shift_en,
  input  logic          inject,
  input  mfps_pkg::sum_t fresh,
  input  mfps_pkg::sum_t from_next,
  output mfps_pkg::sum_t q
);
  import mfps_pkg::*;

  sum_t q_r;
  sum_t q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (shift_en) begin
      q_nxt = inject ? fresh : from_next;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

// File: rtl/core/mfps_ctrl.sv
// ----------------------------------------------------------------------------
// mfps_ctrl
// Size register and row/column counters of the streamed matrix.
// ----------------------------------------------------------------------------
module mfps_ctrl #(
  parameter int MAX_SIZE = mfps_pkg::MAX_SIZE_DEF,
  parameter int SZW      = $clog2(MAX_SIZE + 1),
  parameter int CW       = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [mfps_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                       advance,
  output logic [SZW-1:0]             size,
  output logic [CW-1:0]              col,
  output mfps_pkg::pos_t             pos
);
  import mfps_pkg::*;

  localparam int RST_EFF = (SIZE_RST > MAX_SIZE) ? MAX_SIZE : SIZE_RST;

  logic [SZW-1:0] size_r, size_nxt;
  logic [CW-1:0]  row_r, row_nxt;
  logic [CW-1:0]  col_r, col_nxt;
  logic           last_col, last_row;

  assign last_col = (SZW'(col_r) + SZW'(1)) == size_r;
  assign last_row = (SZW'(row_r) + SZW'(1)) == size_r;

  always_comb begin
    size_nxt = size_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    if (cfg_wr_en) begin
      // zero means one, anything above the capacity saturates
      if (cfg_wr_data == '0) begin
        size_nxt = SZW'(1);
      end else if (32'(cfg_wr_data) > 32'(MAX_SIZE)) begin
        size_nxt = SZW'(MAX_SIZE);
      end else begin
        size_nxt = SZW'(cfg_wr_data);
      end
      row_nxt = '0;
      col_nxt = '0;
    end else if (advance) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + CW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SZW'(RST_EFF);
      row_r  <= '0;
      col_r  <= '0;
    end else begin
      size_r <= size_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
    end
  end

  assign size          = size_r;
  assign col           = col_r;
  assign pos.first_row = (row_r == '0);
  assign pos.last_row  = last_row;
  assign pos.first_col = (col_r == '0);
  assign pos.last_col  = last_col;
  assign pos.has_right = !last_col;

endmodule

// File: rtl/core/min_falling_path_sum.sv
// The result appears on out_valid in the cycle after the matrix's last item is taken.
// Throughput: one item per clock while in_stall is low; the shift line of best sums moves once per item.
// The input stalls only when a last item arrives while a previous result is stalled.
// Reset (rst_n, synchronous): counters and output valid clear, matrix size reads 64, or MAX_SIZE if smaller.
// The best-sum line needs no clearing; it is always refilled before use.
// ----------------------------------------------------------------------------
// min_falling_path_sum
// Streamed minimum falling path sum over a square matrix, one element per item.
// ----------------------------------------------------------------------------
module min_falling_path_sum #(
  parameter int MAX_SIZE = mfps_pkg::MAX_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [mfps_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [mfps_pkg::ELEM_W-1:0] in_element_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [mfps_pkg::SUM_W-1:0]  out_min_path_sum
);
  import mfps_pkg::*;

  localparam int SZW = $clog2(MAX_SIZE + 1);
  localparam int CW  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

  logic           in_acc;
  logic [SZW-1:0] size;
  logic [CW-1:0]  col;
  pos_t           pos;

  sum_t           line_q [MAX_SIZE];
  logic           inject [MAX_SIZE];
  sum_t           tap_here, tap_right;
  sum_t           fresh, best;
  sum_t           saved_left_r, saved_left_nxt;
  sum_t           run_min_r, run_min_nxt;
  logic           out_valid_r, out_valid_nxt;
  sum_t           out_sum_r, out_sum_nxt;

  assign in_stall = out_valid_r && out_stall && pos.last_row && pos.last_col;
  assign in_acc   = in_valid && !in_stall;

  mfps_ctrl #(
    .MAX_SIZE (MAX_SIZE),
    .SZW      (SZW),
    .CW       (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .advance     (in_acc),
    .size        (size),
    .col         (col),
    .pos         (pos)
  );

  // Fresh sums enter at slot size-1 and reach slot 0 one row later.
  for (genvar k = 0; k < MAX_SIZE; k++) begin : g_line
    assign inject[k] = (size == SZW'(k + 1));
    if (k == MAX_SIZE - 1) begin : g_tail
      mfps_cell u_cell (
        .clk       (clk),
        .shift_en  (in_acc),
        .inject    (inject[k]),
        .fresh     (fresh),
        .from_next (fresh),
        .q         (line_q[k])
      );
    end else begin : g_body
      mfps_cell u_cell (
        .clk       (clk),
        .shift_en  (in_acc),
        .inject    (inject[k]),
        .fresh     (fresh),
        .from_next (line_q[k+1]),
        .q         (line_q[k])
      );
    end
  end

  assign tap_here = line_q[0];
  if (MAX_SIZE > 1) begin : g_right
    assign tap_right = line_q[1];
  end else begin : g_no_right
    assign tap_right = '0;
  end

  always_comb begin
    best = tap_here;
    if (!pos.first_col && (saved_left_r < best)) begin
      best = saved_left_r;
    end
    if (pos.has_right && (tap_right < best)) begin
      best = tap_right;
    end
    if (pos.first_row) begin
      fresh = SUM_W'(in_element_value);
    end else begin
      fresh = SUM_W'(in_element_value) + best;
    end
  end

  always_comb begin
    saved_left_nxt = saved_left_r;
    run_min_nxt    = run_min_r;
    if (in_acc) begin
      saved_left_nxt = tap_here;
      if (pos.last_row && (pos.first_col || (fresh < run_min_r))) begin
        run_min_nxt = fresh;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_sum_nxt   = out_sum_r;
    if (in_acc && pos.last_row && pos.last_col) begin
      out_valid_nxt = 1'b1;
      out_sum_nxt   = run_min_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      saved_left_r <= '0;
      run_min_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      saved_left_r <= saved_left_nxt;
      run_min_r    <= run_min_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sum_r <= out_sum_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_min_path_sum = out_sum_r;

`ifndef SYNTHESIS
  // a result shows up only after the matrix's last item was taken
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_acc && pos.last_row && pos.last_col))
    else $error("result without a last item");

  // the column counter stays inside the configured size
  assert property (@(posedge clk) disable iff (!rst_n)
    SZW'(col) < size)
    else $error("column counter beyond size");

  // the input is held back only while a finished result is stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a pending result");

  // a size write restarts the matrix
  assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> (pos.first_row && pos.first_col))
    else $error("counters not cleared by size write");
`endif

endmodule
